### design/whq_pkg.sv
// Shared types, sizes and a pointer helper for the waypoint history queue.
package whq_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int POS_W   = 16;
    localparam int STEP_W  = 8;
    localparam int COUNT_W = 5;
    localparam int REQ_W   = 3;
    localparam int ENTRY_W = 2 * POS_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_RESET    = 3'd0,
        REQ_PUSH     = 3'd1,
        REQ_PUSH_REL = 3'd2,
        REQ_POP_ONE  = 3'd3,
        REQ_POP_ALL  = 3'd4
    } req_t;

    typedef struct packed {
        logic accept;
        logic adv_load;
        logic dump_read;
        logic out_load;
        logic out_entry;
    } cmd_t;

    typedef struct packed {
        logic need_adv;
        logic dump_go;
        logic dump_last;
    } stat_t;

    // Ring pointer plus an offset of at most DEPTH; one compare and subtract.
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p,
                                              input logic [CW-1:0] n);
        logic [CW:0] s;
        s = (CW+1)'(p) + (CW+1)'(n);
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

endpackage

### design/whq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module whq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/whq_ctrl.sv
// Sequencing state machine: accept, oldest-entry refresh, dump and result load.
module whq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  whq_pkg::stat_t stat,
    output whq_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADV  = 5'b00010,
        S_EMIT = 5'b00100,
        S_DRD  = 5'b01000,
        S_DEM  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (stat.need_adv) begin
                        state_next = S_ADV;
                    end else if (stat.dump_go) begin
                        state_next = S_DRD;
                    end else begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_ADV: begin
                cmd.adv_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DRD: begin
                cmd.dump_read = 1'b1;
                state_next    = S_DEM;
            end
            S_DEM: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_entry = 1'b1;
                    state_next    = stat.dump_last ? S_IDLE : S_DRD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### design/whq_datapath.sv
// Queue ring pointers, newest/second/oldest copies, entry RAM and result register.
module whq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  whq_pkg::cmd_t                       cmd,
    output whq_pkg::stat_t                      stat,
    input  logic [whq_pkg::REQ_W-1:0]           req_type,
    input  logic signed [whq_pkg::POS_W-1:0]    pos_x,
    input  logic signed [whq_pkg::POS_W-1:0]    pos_y,
    input  logic signed [whq_pkg::STEP_W-1:0]   step_x,
    input  logic signed [whq_pkg::STEP_W-1:0]   step_y,
    output logic signed [whq_pkg::POS_W-1:0]    entry_x,
    output logic signed [whq_pkg::POS_W-1:0]    entry_y,
    output logic                                entry_valid,
    output logic                                is_last,
    output logic [whq_pkg::COUNT_W-1:0]         count,
    output logic signed [whq_pkg::POS_W-1:0]    last_x,
    output logic signed [whq_pkg::POS_W-1:0]    last_y,
    output logic signed [whq_pkg::POS_W-1:0]    next_x,
    output logic signed [whq_pkg::POS_W-1:0]    next_y
);

    // Control state
    logic [whq_pkg::AW-1:0] head_reg, head_next;
    logic [whq_pkg::CW-1:0] count_reg, count_next;
    logic [whq_pkg::AW-1:0] dptr_reg, dptr_next;
    logic [whq_pkg::CW-1:0] dleft_reg, dleft_next;

    // Copies of the newest, second newest and oldest entries
    logic [whq_pkg::POS_W-1:0] last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [whq_pkg::POS_W-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic [whq_pkg::POS_W-1:0] old_x_reg, old_x_next, old_y_reg, old_y_next;

    // Result register
    logic [whq_pkg::POS_W-1:0]   o_ex_reg, o_ey_reg, o_lx_reg, o_ly_reg, o_nx_reg, o_ny_reg;
    logic                        o_ev_reg, o_il_reg;
    logic [whq_pkg::COUNT_W-1:0] o_cnt_reg;

    // RAM ports
    logic                        ram_we, ram_re;
    logic [whq_pkg::AW-1:0]      ram_waddr, ram_raddr;
    logic [whq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic                      empty, full, over;
    logic [whq_pkg::POS_W-1:0] base_x, base_y, tgt_x, tgt_y;
    logic [whq_pkg::CW-1:0]    n_m1;
    whq_pkg::req_t             req;

    assign req    = whq_pkg::req_t'(req_type);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == whq_pkg::CW'(whq_pkg::DEPTH));
    assign n_m1   = count_reg - whq_pkg::CW'(1);
    assign base_x = empty ? '0 : last_x_reg;
    assign base_y = empty ? '0 : last_y_reg;

    always_comb begin
        if (req == whq_pkg::REQ_PUSH_REL) begin
            tgt_x = base_x + {{(whq_pkg::POS_W - whq_pkg::STEP_W){step_x[whq_pkg::STEP_W-1]}},
                              step_x};
            tgt_y = base_y + {{(whq_pkg::POS_W - whq_pkg::STEP_W){step_y[whq_pkg::STEP_W-1]}},
                              step_y};
        end else begin
            tgt_x = pos_x;
            tgt_y = pos_y;
        end
    end

    // Replace the newest entry when the target and the newest two share x, or else y
    assign over = (count_reg > whq_pkg::CW'(1)) &&
                  (((tgt_x == last_x_reg) && (tgt_x == prev_x_reg)) ||
                   ((tgt_y == last_y_reg) && (tgt_y == prev_y_reg)));

    always_comb begin
        stat.need_adv = 1'b0;
        stat.dump_go  = 1'b0;
        case (req) inside
            whq_pkg::REQ_PUSH, whq_pkg::REQ_PUSH_REL: stat.need_adv = !over && full;
            whq_pkg::REQ_POP_ONE: stat.need_adv = (count_reg > whq_pkg::CW'(1));
            whq_pkg::REQ_POP_ALL: stat.dump_go  = !empty;
            default: ;
        endcase
        stat.dump_last = (dleft_reg == '0);
    end

    // Next state of the queue
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        dptr_next   = dptr_reg;
        dleft_next  = dleft_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        old_x_next  = old_x_reg;
        old_y_next  = old_y_reg;
        ram_we      = 1'b0;
        ram_waddr   = whq_pkg::ptr_add(head_reg, count_reg);
        ram_wdata   = {tgt_x, tgt_y};
        ram_re      = 1'b0;
        ram_raddr   = whq_pkg::ptr_add(head_reg, whq_pkg::CW'(1));

        if (cmd.accept) begin
            case (req) inside
                whq_pkg::REQ_RESET: begin
                    head_next   = '0;
                    count_next  = whq_pkg::CW'(1);
                    ram_we      = 1'b1;
                    ram_waddr   = '0;
                    last_x_next = tgt_x;
                    last_y_next = tgt_y;
                    old_x_next  = tgt_x;
                    old_y_next  = tgt_y;
                end
                whq_pkg::REQ_PUSH, whq_pkg::REQ_PUSH_REL: begin
                    ram_we      = 1'b1;
                    last_x_next = tgt_x;
                    last_y_next = tgt_y;
                    if (over) begin
                        ram_waddr = whq_pkg::ptr_add(head_reg, n_m1);
                    end else begin
                        prev_x_next = last_x_reg;
                        prev_y_next = last_y_reg;
                        if (full) begin
                            // Drop the oldest; its slot takes the new entry
                            ram_re    = 1'b1;
                            head_next = whq_pkg::ptr_add(head_reg, whq_pkg::CW'(1));
                        end else begin
                            count_next = count_reg + whq_pkg::CW'(1);
                            if (empty) begin
                                old_x_next = tgt_x;
                                old_y_next = tgt_y;
                            end
                        end
                    end
                end
                whq_pkg::REQ_POP_ONE: begin
                    if (count_reg > whq_pkg::CW'(1)) begin
                        ram_re     = 1'b1;
                        head_next  = whq_pkg::ptr_add(head_reg, whq_pkg::CW'(1));
                        count_next = n_m1;
                    end
                end
                whq_pkg::REQ_POP_ALL: begin
                    if (!empty) begin
                        dptr_next  = head_reg;
                        dleft_next = count_reg;
                        head_next  = whq_pkg::ptr_add(head_reg, n_m1);
                        count_next = whq_pkg::CW'(1);
                        old_x_next = last_x_reg;
                        old_y_next = last_y_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.adv_load) begin
            old_x_next = ram_rdata[whq_pkg::ENTRY_W-1:whq_pkg::POS_W];
            old_y_next = ram_rdata[whq_pkg::POS_W-1:0];
        end

        if (cmd.dump_read) begin
            ram_re     = 1'b1;
            ram_raddr  = dptr_reg;
            dptr_next  = whq_pkg::ptr_add(dptr_reg, whq_pkg::CW'(1));
            dleft_next = dleft_reg - whq_pkg::CW'(1);
        end
    end

    whq_ram #(
        .WIDTH (whq_pkg::ENTRY_W),
        .DEPTH (whq_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            dptr_reg  <= '0;
            dleft_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            dptr_reg  <= dptr_next;
            dleft_reg <= dleft_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_x_reg <= last_x_next;
        last_y_reg <= last_y_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        old_x_reg  <= old_x_next;
        old_y_reg  <= old_y_next;
        if (cmd.out_load) begin
            o_ex_reg  <= cmd.out_entry ? ram_rdata[whq_pkg::ENTRY_W-1:whq_pkg::POS_W] : '0;
            o_ey_reg  <= cmd.out_entry ? ram_rdata[whq_pkg::POS_W-1:0] : '0;
            o_ev_reg  <= cmd.out_entry;
            o_il_reg  <= cmd.out_entry ? (dleft_reg == '0) : 1'b1;
            o_cnt_reg <= whq_pkg::COUNT_W'(count_reg);
            o_lx_reg  <= empty ? '0 : last_x_reg;
            o_ly_reg  <= empty ? '0 : last_y_reg;
            o_nx_reg  <= empty ? '0 : old_x_reg;
            o_ny_reg  <= empty ? '0 : old_y_reg;
        end
    end

    assign entry_x     = o_ex_reg;
    assign entry_y     = o_ey_reg;
    assign entry_valid = o_ev_reg;
    assign is_last     = o_il_reg;
    assign count       = o_cnt_reg;
    assign last_x      = o_lx_reg;
    assign last_y      = o_ly_reg;
    assign next_x      = o_nx_reg;
    assign next_y      = o_ny_reg;

endmodule

### design/waypoint_history_queue_core.sv
// Top level of the waypoint history queue: controller plus datapath.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_valid / s_ready  | req_type, pos_x, pos_y, step_x, step_y
//  m_      | out | m_valid / m_ready  | entry_x/y, entry_valid, is_last, count,
//          |     |                    | last_x/y, next_x/y
//
//  Reset, push, relative push and ignored requests go from accept straight to emit.
//  Pop one with more than one entry and a push that drops the oldest entry of a full
//  queue add a refresh step: the new oldest entry comes back through the registered
//  read port. Pop all on a non-empty queue is accepted, then each stored entry is one
//  RAM read, then one beat. Pop all on an empty queue goes from accept to emit.
//  Reset clears only the pointers, counters and control state; the RAM needs no clearing pass.
//  A stalled result beat holds the machine in its emit state; a new request is
//  taken while the previous result still waits in the output register.
module waypoint_history_queue_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [whq_pkg::REQ_W-1:0]           s_req_type,
    input  logic signed [whq_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [whq_pkg::POS_W-1:0]    s_pos_y,
    input  logic signed [whq_pkg::STEP_W-1:0]   s_step_x,
    input  logic signed [whq_pkg::STEP_W-1:0]   s_step_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [whq_pkg::POS_W-1:0]    m_entry_x,
    output logic signed [whq_pkg::POS_W-1:0]    m_entry_y,
    output logic                                m_entry_valid,
    output logic                                m_is_last,
    output logic [whq_pkg::COUNT_W-1:0]         m_count,
    output logic signed [whq_pkg::POS_W-1:0]    m_last_x,
    output logic signed [whq_pkg::POS_W-1:0]    m_last_y,
    output logic signed [whq_pkg::POS_W-1:0]    m_next_x,
    output logic signed [whq_pkg::POS_W-1:0]    m_next_y
);

    whq_pkg::cmd_t  cmd;
    whq_pkg::stat_t stat;

    // Sequence each request: accept, refresh oldest, dump entries, load result
    whq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the queue in a ring buffer with copies of newest, second and oldest
    whq_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (s_req_type),
        .pos_x       (s_pos_x),
        .pos_y       (s_pos_y),
        .step_x      (s_step_x),
        .step_y      (s_step_y),
        .entry_x     (m_entry_x),
        .entry_y     (m_entry_y),
        .entry_valid (m_entry_valid),
        .is_last     (m_is_last),
        .count       (m_count),
        .last_x      (m_last_x),
        .last_y      (m_last_y),
        .next_x      (m_next_x),
        .next_y      (m_next_y)
    );

endmodule
